/* rtl/session_table_ttl_evict_unit_defines.svh */
// Assertion helpers for the session table. Each macro checks an implication
// on the rising clock edge and is quiet while reset is held.
`ifndef SESSION_TABLE_TTL_EVICT_UNIT_DEFINES_SVH
`define SESSION_TABLE_TTL_EVICT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define STTE_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("session table check failed");
`define STTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("session table check failed");
`else
`define STTE_ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define STTE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/stte_pkg.sv */
package stte_pkg;

    localparam int REQ_W      = 2;
    localparam int STAT_W     = 2;
    localparam int TIME_W     = 32;
    localparam int TTL_W      = 32;
    localparam int EXP_W      = 33;
    localparam int VIS_W      = 32;
    localparam int LIMIT_W    = 5;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Entry record layout: {key, created, expiry, visits}.
    localparam int VIS_LO     = 0;
    localparam int EXP_LO     = VIS_LO + VIS_W;
    localparam int CRT_LO     = EXP_LO + EXP_W;
    localparam int REC_META_W = CRT_LO + TIME_W;

    localparam logic [TTL_W-1:0]   TTL_RESET   = 32'd3600;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CREATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_VISIT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SWEEP  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DUP     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TTL   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'd1;

    typedef struct packed {
        logic key_eq;
        logic older;
        logic expired;
    } t_cmp_flags;

endpackage

/* rtl/stte_req_if.sv */
interface stte_req_if import stte_pkg::*; #(
    parameter int KEY_BITS = 64
) ();
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [KEY_BITS-1:0] session_key;
    logic [KEY_BITS-1:0] fresh_key;
    logic [TIME_W-1:0]   now_seconds;

    modport source (
        output valid, req_type, session_key, fresh_key, now_seconds,
        input  ready
    );
    modport sink (
        input  valid, req_type, session_key, fresh_key, now_seconds,
        output ready
    );
endinterface

/* rtl/stte_rsp_if.sv */
interface stte_rsp_if import stte_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [VIS_W-1:0]  visit_count;
    logic [TIME_W-1:0] created_time;
    logic [EXP_W-1:0]  expiry_time;
    logic [CNT_W-1:0]  removed_count;
    logic [CNT_W-1:0]  live_count;

    modport source (
        output valid, status, visit_count, created_time, expiry_time,
               removed_count, live_count,
        input  ready
    );
    modport sink (
        input  valid, status, visit_count, created_time, expiry_time,
               removed_count, live_count,
        output ready
    );
endinterface

/* rtl/stte_mem.sv */
module stte_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int W     = 161
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/stte_cmp.sv */
module stte_cmp import stte_pkg::*; #(
    parameter int KEY_BITS = 64
) (
    input  logic [KEY_BITS-1:0] i_rec_key,
    input  logic [TIME_W-1:0]   i_rec_created,
    input  logic [EXP_W-1:0]    i_rec_expiry,
    input  logic [KEY_BITS-1:0] i_probe_key,
    input  logic [KEY_BITS-1:0] i_best_key,
    input  logic [TIME_W-1:0]   i_best_created,
    input  logic [TIME_W-1:0]   i_now,
    output t_cmp_flags          o_flags
);
    always_comb begin
        o_flags.key_eq  = (i_rec_key == i_probe_key);
        // Oldest creation time wins; equal times fall to the lower key.
        o_flags.older   = (i_rec_created < i_best_created) ||
                          ((i_rec_created == i_best_created) && (i_rec_key < i_best_key));
        o_flags.expired = (i_rec_expiry <= {1'b0, i_now});
    end
endmodule

/* rtl/session_table_ttl_evict_unit.sv */
// Keyed session table with time-to-live and oldest-first eviction. A request
// (lookup, create, record visit or sweep) is taken when the unit is idle and
// answered by one result item. The table sits in a record memory with one read
// and one write port that is scanned one entry per cycle through one shared
// compare unit. A lookup, visit or sweep makes one pass over the table; a create
// makes one pass when the table is below its limit and two when it must first
// evict, and a refused create makes none. The table is empty after reset with
// no clearing pass; the configuration port may be written at any time while no
// request is open.
`include "session_table_ttl_evict_unit_defines.svh"
module session_table_ttl_evict_unit import stte_pkg::*; #(
    parameter int TABLE_ENTRIES = 16,
    parameter int KEY_BITS      = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    stte_req_if.sink              i_req,
    stte_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LCW = $clog2(TABLE_ENTRIES + 1);
    localparam int CW  = (LCW > LIMIT_W) ? LCW : LIMIT_W;
    localparam int RW  = KEY_BITS + REC_META_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [1:0] SC_FIND  = 2'd0;
    localparam logic [1:0] SC_OLD   = 2'd1;
    localparam logic [1:0] SC_DUP   = 2'd2;
    localparam logic [1:0] SC_SWEEP = 2'd3;

    localparam logic [LCW-1:0] N_ENT = LCW'(TABLE_ENTRIES);

    logic [2:0]               r_state, n_state;
    logic [1:0]               r_op, n_op;
    logic [REQ_W-1:0]         r_req_type, n_req_type;
    logic [KEY_BITS-1:0]      r_skey, n_skey;
    logic [KEY_BITS-1:0]      r_fkey, n_fkey;
    logic [TIME_W-1:0]        r_now, n_now;
    logic [LCW-1:0]           r_cnt, n_cnt;
    logic                     r_proc, n_proc;
    logic [IW-1:0]            r_pidx, n_pidx;
    logic                     r_found, n_found;
    logic [IW-1:0]            r_fidx, n_fidx;
    logic [RW-1:0]            r_frec, n_frec;
    logic                     r_dup, n_dup;
    logic                     r_free_ok, n_free_ok;
    logic [IW-1:0]            r_free, n_free;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [LCW-1:0]           r_live, n_live;
    logic [LCW-1:0]           r_rem, n_rem;
    logic [STAT_W-1:0]        r_status, n_status;
    logic [VIS_W-1:0]         r_res_vis, n_res_vis;
    logic [TIME_W-1:0]        r_res_crt, n_res_crt;
    logic [EXP_W-1:0]         r_res_exp, n_res_exp;
    logic                     r_ovalid, n_ovalid;
    logic [STAT_W-1:0]        r_o_status, n_o_status;
    logic [VIS_W-1:0]         r_o_vis, n_o_vis;
    logic [TIME_W-1:0]        r_o_crt, n_o_crt;
    logic [EXP_W-1:0]         r_o_exp, n_o_exp;
    logic [CNT_W-1:0]         r_o_rem, n_o_rem;
    logic [CNT_W-1:0]         r_o_live, n_o_live;
    logic [TTL_W-1:0]         r_ttl;
    logic [LIMIT_W-1:0]       r_limit;

    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic [RW-1:0]       mem_wdata;
    logic [IW-1:0]       mem_raddr;
    logic [RW-1:0]       mem_rdata;
    logic [RW-1:0]       cmp_rec;
    logic [KEY_BITS-1:0] cmp_probe;
    t_cmp_flags          flags;
    logic                pv;
    logic [CW-1:0]       limit_ext;
    logic [CW-1:0]       limit_eff;
    logic [CW-1:0]       live_ext;
    logic [EXP_W-1:0]    new_exp;
    logic [VIS_W-1:0]    frec_vis;
    logic [VIS_W-1:0]    vis_bump;
    logic                fin_insert;
    logic                fin_evict;
    logic                done_post;

    stte_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IW),
        .W     (RW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The finish step checks the held record; the scan checks the memory output.
    assign cmp_rec   = (r_state == ST_FIN) ? r_frec : mem_rdata;
    assign cmp_probe = (r_op == SC_DUP) ? r_fkey : r_skey;

    stte_cmp #(
        .KEY_BITS (KEY_BITS)
    ) u_cmp (
        .i_rec_key      (cmp_rec[RW-1:REC_META_W]),
        .i_rec_created  (cmp_rec[CRT_LO +: TIME_W]),
        .i_rec_expiry   (cmp_rec[EXP_LO +: EXP_W]),
        .i_probe_key    (cmp_probe),
        .i_best_key     (r_frec[RW-1:REC_META_W]),
        .i_best_created (r_frec[CRT_LO +: TIME_W]),
        .i_now          (r_now),
        .o_flags        (flags)
    );

    assign pv        = r_valid[r_pidx];
    assign limit_ext = CW'(r_limit);
    assign limit_eff = (limit_ext > CW'(TABLE_ENTRIES)) ? CW'(TABLE_ENTRIES) : limit_ext;
    assign live_ext  = CW'(r_live);
    assign new_exp   = {1'b0, r_now} + {1'b0, r_ttl};
    assign frec_vis  = r_frec[VIS_LO +: VIS_W];
    assign vis_bump  = (frec_vis == '1) ? frec_vis : frec_vis + VIS_W'(1);

    assign i_req.ready         = (r_state == ST_IDLE);
    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.visit_count   = r_o_vis;
    assign o_rsp.created_time  = r_o_crt;
    assign o_rsp.expiry_time   = r_o_exp;
    assign o_rsp.removed_count = r_o_rem;
    assign o_rsp.live_count    = r_o_live;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_req_type = r_req_type;
        n_skey     = r_skey;
        n_fkey     = r_fkey;
        n_now      = r_now;
        n_cnt      = r_cnt;
        n_proc     = r_proc;
        n_pidx     = r_pidx;
        n_found    = r_found;
        n_fidx     = r_fidx;
        n_frec     = r_frec;
        n_dup      = r_dup;
        n_free_ok  = r_free_ok;
        n_free     = r_free;
        n_valid    = r_valid;
        n_live     = r_live;
        n_rem      = r_rem;
        n_status   = r_status;
        n_res_vis  = r_res_vis;
        n_res_crt  = r_res_crt;
        n_res_exp  = r_res_exp;
        n_ovalid   = r_ovalid && !o_rsp.ready;
        n_o_status = r_o_status;
        n_o_vis    = r_o_vis;
        n_o_crt    = r_o_crt;
        n_o_exp    = r_o_exp;
        n_o_rem    = r_o_rem;
        n_o_live   = r_o_live;
        mem_we     = 1'b0;
        mem_waddr  = r_fidx;
        mem_wdata  = r_frec;
        mem_raddr  = r_cnt[IW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_req_type = i_req.req_type;
                    n_skey     = i_req.session_key;
                    n_fkey     = i_req.fresh_key;
                    n_now      = i_req.now_seconds;
                    n_state    = ST_START;
                end
            end
            ST_START: begin
                n_cnt     = '0;
                n_proc    = 1'b0;
                n_found   = 1'b0;
                n_dup     = 1'b0;
                n_free_ok = 1'b0;
                n_rem     = '0;
                n_status  = STAT_OK;
                n_res_vis = '0;
                n_res_crt = '0;
                n_res_exp = '0;
                n_state   = ST_SCAN;
                case (r_req_type) inside
                    REQ_LOOKUP, REQ_VISIT: n_op = SC_FIND;
                    REQ_CREATE: begin
                        if (limit_eff == '0) begin
                            n_status = STAT_REFUSED;
                            n_state  = ST_DONE;
                        end else if (live_ext >= limit_eff) begin
                            n_op = SC_OLD;
                        end else begin
                            n_op = SC_DUP;
                        end
                    end
                    default: n_op = SC_SWEEP;
                endcase
            end
            ST_SCAN: begin
                // Reads are issued in the cycle before the compare.
                if (r_cnt != N_ENT) begin
                    n_cnt  = r_cnt + LCW'(1);
                    n_proc = 1'b1;
                    n_pidx = r_cnt[IW-1:0];
                end else begin
                    n_proc  = 1'b0;
                    n_state = ST_FIN;
                end
                if (r_proc) begin
                    case (r_op)
                        SC_FIND: begin
                            if (pv && flags.key_eq && !r_found) begin
                                n_found = 1'b1;
                                n_fidx  = r_pidx;
                                n_frec  = mem_rdata;
                            end
                        end
                        SC_OLD: begin
                            if (pv && (!r_found || flags.older)) begin
                                n_found = 1'b1;
                                n_fidx  = r_pidx;
                                n_frec  = mem_rdata;
                            end
                        end
                        SC_DUP: begin
                            if (pv && flags.key_eq) begin
                                n_dup = 1'b1;
                            end
                            if (!pv && !r_free_ok) begin
                                n_free_ok = 1'b1;
                                n_free    = r_pidx;
                            end
                        end
                        default: begin
                            if (pv && flags.expired) begin
                                n_valid[r_pidx] = 1'b0;
                                n_live          = r_live - LCW'(1);
                                n_rem           = r_rem + LCW'(1);
                            end
                        end
                    endcase
                end
            end
            ST_FIN: begin
                n_state = ST_DONE;
                case (r_op)
                    SC_FIND: begin
                        if (!r_found || flags.expired) begin
                            n_status = STAT_MISSING;
                        end else begin
                            n_res_crt = r_frec[CRT_LO +: TIME_W];
                            n_res_exp = r_frec[EXP_LO +: EXP_W];
                            if (r_req_type == REQ_VISIT) begin
                                n_res_vis = vis_bump;
                                mem_we    = 1'b1;
                                mem_waddr = r_fidx;
                                mem_wdata = {r_frec[RW-1:VIS_W], vis_bump};
                            end else begin
                                n_res_vis = frec_vis;
                            end
                        end
                    end
                    SC_OLD: begin
                        n_valid[r_fidx] = 1'b0;
                        n_live          = r_live - LCW'(1);
                        n_rem           = LCW'(1);
                        n_op            = SC_DUP;
                        n_cnt           = '0;
                        n_found         = 1'b0;
                        n_state         = ST_SCAN;
                    end
                    SC_DUP: begin
                        if (r_dup) begin
                            n_status = STAT_DUP;
                        end else begin
                            mem_we          = 1'b1;
                            mem_waddr       = r_free;
                            mem_wdata       = {r_fkey, r_now, new_exp, VIS_W'(1)};
                            n_valid[r_free] = 1'b1;
                            n_live          = r_live + LCW'(1);
                            n_res_vis       = VIS_W'(1);
                            n_res_crt       = r_now;
                            n_res_exp       = new_exp;
                        end
                    end
                    default: begin
                        n_status = STAT_OK;
                    end
                endcase
            end
            ST_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_vis    = r_res_vis;
                    n_o_crt    = r_res_crt;
                    n_o_exp    = r_res_exp;
                    n_o_rem    = CNT_W'(r_rem);
                    n_o_live   = CNT_W'(r_live);
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= SC_FIND;
            r_cnt    <= '0;
            r_proc   <= 1'b0;
            r_found  <= 1'b0;
            r_dup    <= 1'b0;
            r_free_ok <= 1'b0;
            r_valid  <= '0;
            r_live   <= '0;
            r_rem    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_cnt     <= n_cnt;
            r_proc    <= n_proc;
            r_found   <= n_found;
            r_dup     <= n_dup;
            r_free_ok <= n_free_ok;
            r_valid   <= n_valid;
            r_live    <= n_live;
            r_rem     <= n_rem;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_type <= n_req_type;
        r_skey     <= n_skey;
        r_fkey     <= n_fkey;
        r_now      <= n_now;
        r_pidx     <= n_pidx;
        r_fidx     <= n_fidx;
        r_frec     <= n_frec;
        r_free     <= n_free;
        r_status   <= n_status;
        r_res_vis  <= n_res_vis;
        r_res_crt  <= n_res_crt;
        r_res_exp  <= n_res_exp;
        r_o_status <= n_o_status;
        r_o_vis    <= n_o_vis;
        r_o_crt    <= n_o_crt;
        r_o_exp    <= n_o_exp;
        r_o_rem    <= n_o_rem;
        r_o_live   <= n_o_live;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl   <= TTL_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TTL:   r_ttl   <= i_cfg_data[TTL_W-1:0];
                CFG_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                default:   r_ttl   <= r_ttl;
            endcase
        end
    end

    assign fin_insert = (r_state == ST_FIN) && (r_op == SC_DUP) && !r_dup;
    assign fin_evict  = (r_state == ST_FIN) && (r_op == SC_OLD);
    assign done_post  = (r_state == ST_DONE) && (!r_ovalid || o_rsp.ready);

    // The running occupancy must track the valid bits exactly.
    `STTE_ASSERT_HOLDS(a_live_matches_valid, i_clk, i_rst_n, 1'b1, r_live == LCW'($countones(r_valid)))
    // An insert always lands on a slot that the scan found free.
    `STTE_ASSERT_HOLDS(a_insert_free_slot, i_clk, i_rst_n, fin_insert, r_free_ok && !r_valid[r_free])
    // Eviction only happens once the scan has picked a victim.
    `STTE_ASSERT_HOLDS(a_evict_has_victim, i_clk, i_rst_n, fin_evict, r_found && r_valid[r_fidx])
    // A finished request is posted and the unit reopens on the next cycle.
    `STTE_ASSERT_NEXT(a_done_posts_result, i_clk, i_rst_n, done_post, r_ovalid && (r_state == ST_IDLE))
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import stte_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BITS      = 64;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int POOL_SIZE     = 24;

    typedef struct packed {
        logic [REQ_W-1:0]    kind;
        logic [KEY_BITS-1:0] session_key;
        logic [KEY_BITS-1:0] fresh_key;
        logic [TIME_W-1:0]   now_sec;
    } session_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VIS_W-1:0]  visit_count;
        logic [TIME_W-1:0] created_time;
        logic [EXP_W-1:0]  expiry_time;
        logic [CNT_W-1:0]  removed_count;
        logic [CNT_W-1:0]  live_count;
    } session_rsp_t;

    class session_scoreboard;
        bit                  slot_used   [TABLE_ENTRIES];
        logic [KEY_BITS-1:0] slot_key    [TABLE_ENTRIES];
        logic [TIME_W-1:0]   slot_born   [TABLE_ENTRIES];
        logic [EXP_W-1:0]    slot_expiry [TABLE_ENTRIES];
        logic [VIS_W-1:0]    slot_visits [TABLE_ENTRIES];
        logic [TTL_W-1:0]    ttl;
        logic [LIMIT_W-1:0]  limit;
        session_rsp_t        due_results[$];
        int                  errors;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            ttl    = TTL_RESET;
            limit  = LIMIT_RESET;
            errors = 0;
        endfunction

        function int find_key(logic [KEY_BITS-1:0] key);
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (slot_used[i] && slot_key[i] == key) return i;
            return -1;
        endfunction

        function int live_entries();
            int n = 0;
            foreach (slot_used[i]) if (slot_used[i]) n++;
            return n;
        endfunction

        function void fill_entry(ref session_rsp_t r, input int s);
            r.visit_count  = slot_visits[s];
            r.created_time = slot_born[s];
            r.expiry_time  = slot_expiry[s];
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Applies one accepted request to the table copy and queues its answer.
        function void note_request(session_req_t r);
            session_rsp_t e;
            int s;
            int cap;
            int oldest;
            e = '0;
            case (r.kind)
                REQ_LOOKUP, REQ_VISIT: begin
                    s = find_key(r.session_key);
                    // An expired entry reads as missing but stays in place.
                    if (s < 0 || !({1'b0, r.now_sec} < slot_expiry[s])) begin
                        e.status = STAT_MISSING;
                    end else begin
                        if (r.kind == REQ_VISIT && slot_visits[s] != '1)
                            slot_visits[s] = slot_visits[s] + 1'b1;
                        e.status = STAT_OK;
                        fill_entry(e, s);
                    end
                end
                REQ_CREATE: begin
                    cap = (limit > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(limit);
                    if (cap == 0) begin
                        e.status = STAT_REFUSED;
                    end else begin
                        if (live_entries() >= cap) begin
                            oldest = -1;
                            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                                if (!slot_used[i]) continue;
                                if (oldest < 0 || slot_born[i] < slot_born[oldest] ||
                                    (slot_born[i] == slot_born[oldest] &&
                                     slot_key[i] < slot_key[oldest]))
                                    oldest = i;
                            end
                            if (oldest >= 0) begin
                                slot_used[oldest] = 1'b0;
                                e.removed_count   = CNT_W'(1);
                            end
                        end
                        // The eviction above stands even when the key turns out taken.
                        if (find_key(r.fresh_key) >= 0) begin
                            e.status = STAT_DUP;
                        end else begin
                            s = -1;
                            for (int i = 0; i < TABLE_ENTRIES; i++)
                                if (!slot_used[i] && s < 0) s = i;
                            slot_used[s]   = 1'b1;
                            slot_key[s]    = r.fresh_key;
                            slot_born[s]   = r.now_sec;
                            slot_expiry[s] = {1'b0, r.now_sec} + {1'b0, ttl};
                            slot_visits[s] = VIS_W'(1);
                            e.status       = STAT_OK;
                            fill_entry(e, s);
                        end
                    end
                end
                default: begin
                    e.status = STAT_OK;
                    foreach (slot_used[i]) begin
                        if (slot_used[i] && slot_expiry[i] <= {1'b0, r.now_sec}) begin
                            slot_used[i]    = 1'b0;
                            e.removed_count = e.removed_count + 1'b1;
                        end
                    end
                end
            endcase
            e.live_count = CNT_W'(live_entries());
            due_results.push_back(e);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(session_rsp_t got);
            session_rsp_t want;
            if (due_results.size() == 0) begin
                $error("result item arrived with no request outstanding");
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("visit_count", 64'(want.visit_count), 64'(got.visit_count));
            compare_field("created_time", 64'(want.created_time), 64'(got.created_time));
            compare_field("expiry_time", 64'(want.expiry_time), 64'(got.expiry_time));
            compare_field("removed_count", 64'(want.removed_count),
                          64'(got.removed_count));
            compare_field("live_count", 64'(want.live_count), 64'(got.live_count));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    stte_req_if #(.KEY_BITS(KEY_BITS)) req_ch ();
    stte_rsp_if                        rsp_ch ();

    session_table_ttl_evict_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .KEY_BITS     (KEY_BITS)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .o_rsp     (rsp_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    session_scoreboard   sb;
    int                  cycle_count = 0;
    int                  rx_hold_cycles = 0;
    bit                  no_idle = 1'b0;
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
    logic [KEY_BITS-1:0] last_fresh;
    logic [TIME_W-1:0]   clock_now;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [KEY_BITS-1:0] skey,
                            input logic [KEY_BITS-1:0] fkey, input logic [TIME_W-1:0] now_sec);
        int gap;
        session_req_t r;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        // Valid stays high straight into the next item when there is no gap.
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.session_key <= skey;
        req_ch.fresh_key   <= fkey;
        req_ch.now_seconds <= now_sec;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        r.kind        = kind;
        r.session_key = skey;
        r.fresh_key   = fkey;
        r.now_sec     = now_sec;
        sb.note_request(r);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == CFG_TTL) sb.ttl = data;
        else sb.limit = data[LIMIT_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // One configuration setting followed by random traffic. Most requests reuse a
    // small key pool and a slowly moving clock so that hits, expiries, evictions
    // and duplicates happen often.
    task automatic run_phase(input logic [TTL_W-1:0] ttl, input logic [LIMIT_W-1:0] lim,
                             input int count, input logic [TIME_W-1:0] start,
                             input int max_step, input int span,
                             input int hold_at, input int pause_at);
        int roll;
        int step_roll;
        int pick;
        logic [REQ_W-1:0]    kind;
        logic [KEY_BITS-1:0] skey;
        logic [KEY_BITS-1:0] fkey;
        logic [TIME_W-1:0]   now_sec;
        wait_idle();
        write_cfg(CFG_TTL, ttl);
        write_cfg(CFG_LIMIT, CFG_DATA_W'(lim));
        clock_now = start;
        for (int i = 0; i < count; i++) begin
            no_idle = (i >= count / 2 && i < count / 2 + 25);
            if (i == hold_at) rx_hold_cycles = 400;
            if (i == pause_at) wait_idle();
            step_roll = $urandom_range(0, 9);
            if (step_roll >= 4 && step_roll < 9)
                clock_now = clock_now + TIME_W'($urandom_range(1, max_step));
            else if (step_roll == 9)
                clock_now = clock_now - TIME_W'($urandom_range(1, max_step));
            now_sec = clock_now;
            fkey = ($urandom_range(0, 6) == 0) ? {$urandom, $urandom}
                                                : key_pool[$urandom_range(0, span - 1)];
            pick = $urandom_range(0, 9);
            if (pick < 3) skey = last_fresh;
            else if (pick < 9) skey = key_pool[$urandom_range(0, span - 1)];
            else skey = {$urandom, $urandom};
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                kind       = REQ_CREATE;
                last_fresh = fkey;
            end else if (roll < 60) begin
                kind = REQ_LOOKUP;
            end else if (roll < 85) begin
                kind = REQ_VISIT;
            end else if (roll < 95) begin
                kind = REQ_SWEEP;
            end else begin
                kind    = REQ_W'($urandom_range(0, 3));
                now_sec = $urandom;
                skey    = {$urandom, $urandom};
                fkey    = {$urandom, $urandom};
            end
            send_req(kind, skey, fkey, now_sec);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        int errs;
        localparam logic [KEY_BITS-1:0] K_ONES = '1;
        localparam logic [KEY_BITS-1:0] K_TOP  = {1'b1, {(KEY_BITS - 1){1'b0}}};
        localparam logic [TIME_W-1:0]   T_MAX  = '1;
        sb                 = new();
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = '0;
        req_ch.session_key = '0;
        req_ch.fresh_key   = '0;
        req_ch.now_seconds = '0;
        rsp_ch.ready       = 1'b0;
        key_pool[0] = '0;
        key_pool[1] = K_ONES;
        key_pool[2] = K_TOP;
        for (int i = 3; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
        last_fresh = key_pool[0];
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: empty table, widest times, duplicates and expiry.
        send_req(REQ_LOOKUP, '0, '0, '0);
        send_req(REQ_SWEEP, '0, K_ONES, '0);
        send_req(REQ_CREATE, K_ONES, '0, '0);
        send_req(REQ_CREATE, '0, K_ONES, T_MAX);
        send_req(REQ_CREATE, '0, '0, 32'd5);
        send_req(REQ_VISIT, '0, '0, 32'd10);
        send_req(REQ_LOOKUP, K_ONES, '0, T_MAX);
        send_req(REQ_VISIT, '0, '0, 32'd3600);
        send_req(REQ_CREATE, '0, '0, 32'd3600);
        send_req(REQ_SWEEP, '0, '0, 32'd3600);
        send_req(REQ_LOOKUP, '0, '0, 32'd3600);

        // A zero limit refuses every create.
        wait_idle();
        write_cfg(CFG_LIMIT, 32'd0);
        send_req(REQ_CREATE, '0, 64'd5, 32'd20);

        // Two entries with no lifetime: eviction order, ties, and a duplicate
        // that the eviction itself removed.
        wait_idle();
        write_cfg(CFG_LIMIT, 32'd2);
        write_cfg(CFG_TTL, 32'd0);
        send_req(REQ_CREATE, '0, 64'd7, 32'd100);
        send_req(REQ_LOOKUP, 64'd7, '0, 32'd100);
        send_req(REQ_CREATE, '0, 64'd3, 32'd100);
        send_req(REQ_CREATE, '0, 64'd3, 32'd100);
        send_req(REQ_CREATE, '0, 64'd9, 32'd100);
        send_req(REQ_CREATE, '0, K_ONES, 32'd100);
        send_req(REQ_CREATE, '0, 64'd8, T_MAX);
        send_req(REQ_CREATE, '0, 64'd4, 32'd7);
        send_req(REQ_LOOKUP, K_ONES, '0, '0);

        // Longest lifetime, then a limit dropped below the occupancy.
        wait_idle();
        write_cfg(CFG_LIMIT, 32'd16);
        write_cfg(CFG_TTL, 32'hFFFF_FFFF);
        send_req(REQ_CREATE, '0, K_TOP, T_MAX);
        send_req(REQ_VISIT, K_TOP, '0, T_MAX - 1);
        wait_idle();
        write_cfg(CFG_LIMIT, 32'd1);
        send_req(REQ_CREATE, '0, 64'd6, 32'd1);
        send_req(REQ_SWEEP, '0, '0, T_MAX);

        run_phase(32'd40, 5'd16, 200, $urandom, 6, POOL_SIZE, -1, -1);
        run_phase(32'd0, 5'd4, 120, $urandom, 2, 8, -1, -1);
        run_phase(32'd25, 5'd1, 120, $urandom, 6, 6, -1, -1);
        run_phase(32'd120, 5'd31, 160, $urandom, 20, POOL_SIZE, 60, -1);
        run_phase(32'hFFFF_FFFF, 5'd16, 150, 32'hFFFF_FF00, 3, 20, -1, -1);
        run_phase(32'd10, 5'd0, 60, $urandom, 2, 12, -1, -1);
        run_phase(32'd60, 5'd8, 160, $urandom, 8, 16, -1, 80);
        run_phase(TTL_RESET, LIMIT_RESET, 140, $urandom, 300, POOL_SIZE, -1, -1);

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        errs = sb.errors;
        if (errs == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Result side: random stalls per item, plus one long hold-off on request.
    initial begin
        int gap;
        session_rsp_t got;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles != 0) begin
                gap            = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 13);
            end
            if (gap != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_ch.valid && rsp_ch.ready));
            got.status        = rsp_ch.status;
            got.visit_count   = rsp_ch.visit_count;
            got.created_time  = rsp_ch.created_time;
            got.expiry_time   = rsp_ch.expiry_time;
            got.removed_count = rsp_ch.removed_count;
            got.live_count    = rsp_ch.live_count;
            sb.check_result(got);
        end
    end

endmodule

/* session_table_ttl_evict_unit.f */
+incdir+rtl
rtl/stte_pkg.sv
rtl/stte_req_if.sv
rtl/stte_rsp_if.sv
rtl/stte_mem.sv
rtl/stte_cmp.sv
rtl/session_table_ttl_evict_unit.sv
tb/tb_top.sv
